>>> design/svpt_pkg.sv
// Shared types and constants for the space vector PWM timing block.
// No dependencies; imported by every module of the block.
package svpt_pkg;

    // Fixed-point constants, all scaled by 2^14
    localparam logic [14:0] K_SQRT3        = 15'd28378;
    localparam logic [14:0] K_HALF_SQRT3   = 15'd14189;
    localparam logic [14:0] K_THREE_HALVES = 15'd24576;
    localparam int          FRAC_BITS      = 14;

    // Compare values carry 15 bits; the divider resolves one bit per stage
    localparam int QUO_W = 15;
    localparam int CFG_W = 16;

    // Register reset values
    localparam logic [CFG_W-1:0] PERIOD_RST = 16'd8000;
    localparam logic [CFG_W-1:0] BUS_RST    = 16'd6144;

    // Configuration register indexes
    typedef enum logic {
        CFG_PERIOD = 1'b0,
        CFG_BUS    = 1'b1
    } t_cfg_idx;

    // Sector codes, bit0 = beta>0, bit1 = sqrt3*a>b, bit2 = -sqrt3*a>b
    localparam logic [2:0] SEC_ZERO = 3'd0;
    localparam logic [2:0] SEC_1    = 3'd1;
    localparam logic [2:0] SEC_2    = 3'd2;
    localparam logic [2:0] SEC_3    = 3'd3;
    localparam logic [2:0] SEC_4    = 3'd4;
    localparam logic [2:0] SEC_5    = 3'd5;
    localparam logic [2:0] SEC_6    = 3'd6;

    // Control that travels alongside the datapath
    typedef struct packed {
        logic       vld;
        logic [2:0] sector;
        logic       ovm;
    } t_side;

endpackage

>>> design/svpt_front.sv
// Front end: sector detection, X/Y/Z numerators, active time selection,
// overmodulation test and numerator products. Uses svpt_pkg.
module svpt_front import svpt_pkg::*; #(
    parameter int VW   = 16,
    parameter int NUMW = 48,
    parameter int DENW = 33
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_vld,
    input  logic signed [VW-1:0] i_alpha,
    input  logic signed [VW-1:0] i_beta,
    input  logic [CFG_W-1:0]     i_period,
    input  logic [CFG_W-1:0]     i_bus,
    output t_side                o_side,
    output logic [NUMW-1:0]      o_num_a,
    output logic [NUMW-1:0]      o_num_b,
    output logic [NUMW-1:0]      o_num_c,
    output logic [DENW-1:0]      o_den
);

    localparam int NW = VW + 16;
    localparam int MW = NUMW - 16;
    localparam int DW = CFG_W + FRAC_BITS;
    localparam int SW = 2 * VW;

    function automatic logic [NW-2:0] clamp_pos(input logic signed [NW-1:0] v);
        clamp_pos = v[NW-1] ? '0 : v[NW-2:0];
    endfunction

    // ---------------- stage 1: squares and constant products
    logic signed [SW-1:0] n1_sq_a, n1_sq_b;
    logic signed [NW-1:0] n1_kxb, n1_khb, n1_kta;
    logic                 r1_vld;
    logic [SW-1:0]        r1_sq_a, r1_sq_b;
    logic signed [NW-1:0] r1_kxb, r1_khb, r1_kta;
    logic                 r1_a_neg, r1_a_zero, r1_b_neg, r1_b_pos;

    assign n1_sq_a = i_alpha * i_alpha;
    assign n1_sq_b = i_beta * i_beta;
    assign n1_kxb  = $signed({1'b0, K_SQRT3}) * i_beta;
    assign n1_khb  = $signed({1'b0, K_HALF_SQRT3}) * i_beta;
    assign n1_kta  = $signed({1'b0, K_THREE_HALVES}) * i_alpha;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else if (i_en) begin
            r1_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_sq_a   <= n1_sq_a;
            r1_sq_b   <= n1_sq_b;
            r1_kxb    <= n1_kxb;
            r1_khb    <= n1_khb;
            r1_kta    <= n1_kta;
            r1_a_neg  <= i_alpha[VW-1];
            r1_a_zero <= (i_alpha == '0);
            r1_b_neg  <= i_beta[VW-1];
            r1_b_pos  <= !i_beta[VW-1] && (i_beta != '0);
        end
    end

    // ---------------- stage 2: exact sector tests, X/Y/Z numerators
    logic [SW+1:0]        n2_three_aa, n2_bb;
    logic                 n2_gt, n2_lt, n2_r3p, n2_r3m;
    logic                 r2_vld;
    logic [2:0]           r2_sector;
    logic signed [NW-1:0] r2_nx, r2_ny, r2_nz;

    always_comb begin
        n2_three_aa = {2'b00, r1_sq_a} + {1'b0, r1_sq_a, 1'b0};
        n2_bb       = {2'b00, r1_sq_b};
        n2_gt       = n2_three_aa > n2_bb;
        n2_lt       = n2_three_aa < n2_bb;
        // sqrt3*a > b
        n2_r3p = r1_a_neg ? (r1_b_neg && n2_lt) : (r1_b_neg || n2_gt);
        // -sqrt3*a > b
        n2_r3m = (r1_a_neg || r1_a_zero) ? (r1_b_neg || n2_gt) : (r1_b_neg && n2_lt);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
        end else if (i_en) begin
            r2_vld <= r1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_sector <= {n2_r3m, n2_r3p, r1_b_pos};
            r2_nx     <= r1_kxb;
            r2_ny     <= r1_khb + r1_kta;
            r2_nz     <= r1_khb - r1_kta;
        end
    end

    // ---------------- stage 3: pick the two active times
    logic [NW-2:0] n3_n1, n3_n2;
    logic [DW-1:0] n3_d;
    logic          r3_vld;
    logic [2:0]    r3_sector;
    logic [NW-2:0] r3_n1, r3_n2;
    logic [NW-1:0] r3_s;
    logic [DW-1:0] r3_d;

    always_comb begin
        n3_n1 = '0;
        n3_n2 = '0;
        case (r2_sector)
            SEC_1: begin
                n3_n1 = clamp_pos(r2_nz);
                n3_n2 = clamp_pos(r2_ny);
            end
            SEC_2: begin
                n3_n1 = clamp_pos(r2_ny);
                n3_n2 = clamp_pos(-r2_nx);
            end
            SEC_3: begin
                n3_n1 = clamp_pos(-r2_nz);
                n3_n2 = clamp_pos(r2_nx);
            end
            SEC_4: begin
                n3_n1 = clamp_pos(-r2_nx);
                n3_n2 = clamp_pos(r2_nz);
            end
            SEC_5: begin
                n3_n1 = clamp_pos(r2_nx);
                n3_n2 = clamp_pos(-r2_ny);
            end
            SEC_6: begin
                n3_n1 = clamp_pos(-r2_ny);
                n3_n2 = clamp_pos(-r2_nz);
            end
            default: begin
                n3_n1 = '0;
                n3_n2 = '0;
            end
        endcase
        // zero bus voltage counts as one LSB
        n3_d = {((i_bus == '0) ? CFG_W'(1) : i_bus), {FRAC_BITS{1'b0}}};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_vld <= 1'b0;
        end else if (i_en) begin
            r3_vld <= r2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r3_sector <= r2_sector;
            r3_n1     <= n3_n1;
            r3_n2     <= n3_n2;
            r3_s      <= {1'b0, n3_n1} + {1'b0, n3_n2};
            r3_d      <= n3_d;
        end
    end

    // ---------------- stage 4: overmodulation, multiplicands and divisor
    // Normal: times are P*m/(4D). Overmodulated: P*m/(2s) with m = 0, n1, s.
    logic [MW-1:0]   n4_s, n4_d, n4_n1, n4_n2;
    logic            n4_ov, n4_sec_ok;
    logic            r4_vld;
    logic [2:0]      r4_sector;
    logic            r4_ovm;
    logic [MW-1:0]   r4_ma, r4_mb, r4_mc;
    logic [DENW-1:0] r4_den;

    always_comb begin
        n4_s      = MW'(r3_s);
        n4_d      = MW'(r3_d);
        n4_n1     = MW'(r3_n1);
        n4_n2     = MW'(r3_n2);
        n4_ov     = n4_s > n4_d;
        n4_sec_ok = r3_sector inside {SEC_1, SEC_2, SEC_3, SEC_4, SEC_5, SEC_6};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_vld <= 1'b0;
        end else if (i_en) begin
            r4_vld <= r3_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r4_sector <= r3_sector;
            r4_ovm    <= n4_ov && n4_sec_ok && (i_period != '0);
            r4_ma     <= n4_ov ? '0 : (n4_d - n4_s);
            r4_mb     <= n4_ov ? n4_n1 : (n4_d + n4_n1 - n4_n2);
            r4_mc     <= n4_ov ? n4_s : (n4_d + n4_s);
            r4_den    <= n4_ov ? DENW'({r3_s, 1'b0}) : DENW'({r3_d, 2'b00});
        end
    end

    // ---------------- stage 5: period products
    logic            r5_vld;
    logic [2:0]      r5_sector;
    logic            r5_ovm;
    logic [NUMW-1:0] r5_num_a, r5_num_b, r5_num_c;
    logic [DENW-1:0] r5_den;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_vld <= 1'b0;
        end else if (i_en) begin
            r5_vld <= r4_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r5_sector <= r4_sector;
            r5_ovm    <= r4_ovm;
            r5_num_a  <= NUMW'(i_period) * NUMW'(r4_ma);
            r5_num_b  <= NUMW'(i_period) * NUMW'(r4_mb);
            r5_num_c  <= NUMW'(i_period) * NUMW'(r4_mc);
            r5_den    <= r4_den;
        end
    end

    assign o_side.vld    = r5_vld;
    assign o_side.sector = r5_sector;
    assign o_side.ovm    = r5_ovm;
    assign o_num_a       = r5_num_a;
    assign o_num_b       = r5_num_b;
    assign o_num_c       = r5_num_c;
    assign o_den         = r5_den;

endmodule

>>> design/svpt_div.sv
// Pipelined restoring divider, one quotient bit per stage.
// Uses svpt_pkg for the quotient width.
module svpt_div import svpt_pkg::*; #(
    parameter int NUMW = 48,
    parameter int DENW = 33
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [NUMW-1:0]  i_num,
    input  logic [DENW-1:0]  i_den,
    output logic [QUO_W-1:0] o_quo
);

    localparam int CW = (NUMW > DENW + QUO_W) ? NUMW : DENW + QUO_W;

    logic [NUMW-1:0]  r_rem [QUO_W];
    logic [DENW-1:0]  r_den [QUO_W];
    logic [QUO_W-1:0] r_quo [QUO_W];

    // Stage g resolves quotient bit QUO_W-1-g; the quotient is known to fit
    for (genvar g = 0; g < QUO_W; g++) begin : g_stage
        logic [NUMW-1:0]  rem_in;
        logic [DENW-1:0]  den_in;
        logic [QUO_W-1:0] quo_in;
        logic [CW-1:0]    shifted, rem_ext;
        logic             take;
        logic [NUMW-1:0]  n_rem;
        logic [QUO_W-1:0] n_quo;

        if (g == 0) begin : g_first
            assign rem_in = i_num;
            assign den_in = i_den;
            assign quo_in = '0;
        end else begin : g_next
            assign rem_in = r_rem[g-1];
            assign den_in = r_den[g-1];
            assign quo_in = r_quo[g-1];
        end

        always_comb begin
            rem_ext = CW'(rem_in);
            shifted = CW'(den_in) << (QUO_W - 1 - g);
            take    = rem_ext >= shifted;
            n_rem   = take ? NUMW'(rem_ext - shifted) : rem_in;
            n_quo   = quo_in;
            n_quo[QUO_W-1-g] = take;
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[g] <= n_rem;
                r_den[g] <= den_in;
                r_quo[g] <= n_quo;
            end
        end
    end

    assign o_quo = r_quo[QUO_W-1];

endmodule

>>> design/space_vector_pwm_timing_top.sv
// Space vector PWM timing top level: config registers, front end, three
// dividers, channel mapping and output skid. Uses svpt_pkg, svpt_front, svpt_div.
//
// Takes one (alpha, beta) beat per cycle while o_ready is high and returns one
// result beat per input, in order. A result passes 21 registers: five front-end
// stages (squares, sector test, time selection, overmodulation test, period
// products), fifteen restoring divider stages that settle one compare bit each,
// and the output register. The accepting edge loads the first of them. A skid
// entry behind the output register lets the pipeline keep taking input while a
// result waits; o_ready drops only once that entry is occupied. Configuration
// writes are always accepted and must only be issued while no beat is in flight.
module space_vector_pwm_timing_top import svpt_pkg::*; #(
    parameter int VOLT_WIDTH = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic signed [VOLT_WIDTH-1:0] i_alpha,
    input  logic signed [VOLT_WIDTH-1:0] i_beta,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic                         i_cfg_index,
    input  logic [CFG_W-1:0]             i_cfg_data,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [QUO_W-1:0]             o_compare_a,
    output logic [QUO_W-1:0]             o_compare_b,
    output logic [QUO_W-1:0]             o_compare_c,
    output logic [2:0]                   o_sector_code,
    output logic                         o_overmodulated
);

    localparam int NW   = VOLT_WIDTH + 16;
    localparam int MW   = (NW > 32) ? NW : 32;
    localparam int DENW = (NW + 1 > 32) ? NW + 1 : 32;
    localparam int NUMW = MW + 16;

    // ---------------- configuration registers
    logic [CFG_W-1:0] r_period, r_bus;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period <= PERIOD_RST;
            r_bus    <= BUS_RST;
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_PERIOD: r_period <= i_cfg_data;
                CFG_BUS:    r_bus    <= i_cfg_data;
                default:    r_bus    <= r_bus;
            endcase
        end
    end

    // ---------------- pipeline advance: held only while the skid entry is full
    logic r_skid_vld;
    logic en;

    assign en      = !r_skid_vld;
    assign o_ready = en;

    // ---------------- front end
    t_side           front_side;
    logic [NUMW-1:0] num_a, num_b, num_c;
    logic [DENW-1:0] den;

    svpt_front #(
        .VW   (VOLT_WIDTH),
        .NUMW (NUMW),
        .DENW (DENW)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_vld    (i_valid),
        .i_alpha  (i_alpha),
        .i_beta   (i_beta),
        .i_period (r_period),
        .i_bus    (r_bus),
        .o_side   (front_side),
        .o_num_a  (num_a),
        .o_num_b  (num_b),
        .o_num_c  (num_c),
        .o_den    (den)
    );

    // ---------------- dividers, one per switching time
    logic [QUO_W-1:0] t_a, t_b, t_c;

    svpt_div #(.NUMW(NUMW), .DENW(DENW)) u_div_a (
        .i_clk (i_clk), .i_en (en), .i_num (num_a), .i_den (den), .o_quo (t_a)
    );
    svpt_div #(.NUMW(NUMW), .DENW(DENW)) u_div_b (
        .i_clk (i_clk), .i_en (en), .i_num (num_b), .i_den (den), .o_quo (t_b)
    );
    svpt_div #(.NUMW(NUMW), .DENW(DENW)) u_div_c (
        .i_clk (i_clk), .i_en (en), .i_num (num_c), .i_den (den), .o_quo (t_c)
    );

    // ---------------- sector and valid travel beside the dividers
    t_side r_side [QUO_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < QUO_W; k++) begin
                r_side[k] <= '0;
            end
        end else if (en) begin
            r_side[0] <= front_side;
            for (int k = 1; k < QUO_W; k++) begin
                r_side[k] <= r_side[k-1];
            end
        end
    end

    // ---------------- route the three times to the channels
    t_side            tail;
    logic [QUO_W-1:0] n_ca, n_cb, n_cc;

    assign tail = r_side[QUO_W-1];

    always_comb begin
        n_ca = '0;
        n_cb = '0;
        n_cc = '0;
        case (tail.sector)
            SEC_1: begin n_ca = t_b; n_cb = t_a; n_cc = t_c; end
            SEC_2: begin n_ca = t_a; n_cb = t_c; n_cc = t_b; end
            SEC_3: begin n_ca = t_a; n_cb = t_b; n_cc = t_c; end
            SEC_4: begin n_ca = t_c; n_cb = t_b; n_cc = t_a; end
            SEC_5: begin n_ca = t_c; n_cb = t_a; n_cc = t_b; end
            SEC_6: begin n_ca = t_b; n_cb = t_c; n_cc = t_a; end
            default: begin
                n_ca = '0;
                n_cb = '0;
                n_cc = '0;
            end
        endcase
    end

    // ---------------- output register with one skid entry
    logic             r_out_vld;
    logic [QUO_W-1:0] r_out_a, r_out_b, r_out_c;
    logic [2:0]       r_out_sec;
    logic             r_out_ovm;
    logic [QUO_W-1:0] r_skid_a, r_skid_b, r_skid_c;
    logic [2:0]       r_skid_sec;
    logic             r_skid_ovm;
    logic             load_out, load_skid, drain_skid;

    always_comb begin
        load_out   = en && tail.vld && (!r_out_vld || i_ready);
        load_skid  = en && tail.vld && r_out_vld && !i_ready;
        drain_skid = r_skid_vld && i_ready;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else begin
            if (load_out || drain_skid) begin
                r_out_vld <= 1'b1;
            end else if (i_ready) begin
                r_out_vld <= 1'b0;
            end
            if (load_skid) begin
                r_skid_vld <= 1'b1;
            end else if (drain_skid) begin
                r_skid_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (drain_skid) begin
            r_out_a   <= r_skid_a;
            r_out_b   <= r_skid_b;
            r_out_c   <= r_skid_c;
            r_out_sec <= r_skid_sec;
            r_out_ovm <= r_skid_ovm;
        end else if (load_out) begin
            r_out_a   <= n_ca;
            r_out_b   <= n_cb;
            r_out_c   <= n_cc;
            r_out_sec <= tail.sector;
            r_out_ovm <= tail.ovm;
        end
        if (load_skid) begin
            r_skid_a   <= n_ca;
            r_skid_b   <= n_cb;
            r_skid_c   <= n_cc;
            r_skid_sec <= tail.sector;
            r_skid_ovm <= tail.ovm;
        end
    end

    assign o_valid         = r_out_vld;
    assign o_compare_a     = r_out_a;
    assign o_compare_b     = r_out_b;
    assign o_compare_c     = r_out_c;
    assign o_sector_code   = r_out_sec;
    assign o_overmodulated = r_out_ovm;

endmodule

>>> tb/sv/svpt_checker.sv
// Output checker for the space vector PWM timing block: computes expected compare
// values from each accepted vector beat and compares result beats in order.
// Depends on svpt_pkg for the config register indexes and widths.
module svpt_checker import svpt_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic               i_ready_in,
    input  logic signed [15:0] i_alpha,
    input  logic signed [15:0] i_beta,
    input  logic               i_cfg_valid,
    input  logic               i_cfg_ready,
    input  logic               i_cfg_index,
    input  logic [CFG_W-1:0]   i_cfg_data,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  logic [QUO_W-1:0]   i_compare_a,
    input  logic [QUO_W-1:0]   i_compare_b,
    input  logic [QUO_W-1:0]   i_compare_c,
    input  logic [2:0]         i_sector_code,
    input  logic               i_overmodulated,
    output int                 o_fail_count,
    output int                 o_pending,
    output int                 o_result_count,
    output int                 o_ovm_count
);

    typedef struct packed {
        logic [QUO_W-1:0] ca;
        logic [QUO_W-1:0] cb;
        logic [QUO_W-1:0] cc;
        logic [2:0]       sector;
        logic             ovm;
    } t_timing;

    logic [CFG_W-1:0] period_q;
    logic [CFG_W-1:0] bus_q;
    t_timing          timing_q[$];

    // sqrt3*a > b, exact via squares
    function automatic bit root3_above(longint a, longint b);
        longint aa;
        longint bb;
        aa = (a < 0) ? -a : a;
        bb = (b < 0) ? -b : b;
        if (a >= 0) return (b < 0) ? 1'b1 : (3 * aa * aa > bb * bb);
        if (b >= 0) return 1'b0;
        return 3 * aa * aa < bb * bb;
    endfunction

    function automatic longint non_neg(longint v);
        return (v < 0) ? 0 : v;
    endfunction

    function automatic t_timing svpwm_timing(logic signed [15:0] alpha,
                                             logic signed [15:0] beta);
        t_timing r;
        longint  a;
        longint  b;
        longint  nx;
        longint  ny;
        longint  nz;
        longint  n1;
        longint  n2;
        longint  s;
        longint  p;
        longint  d;
        longint  ta;
        longint  tb;
        longint  tc;
        logic [2:0] sec;
        a = alpha;
        b = beta;
        sec = {root3_above(-a, b), root3_above(a, b), b > 0};
        nx = 28378 * b;
        ny = 14189 * b + 24576 * a;
        nz = 14189 * b - 24576 * a;
        p = period_q;
        d = ((bus_q == 0) ? 1 : longint'(bus_q)) << FRAC_BITS;
        n1 = 0;
        n2 = 0;
        ta = 0;
        tb = 0;
        tc = 0;
        r = '0;
        r.sector = sec;
        case (sec)
            SEC_1: begin n1 = non_neg(nz);  n2 = non_neg(ny);  end
            SEC_2: begin n1 = non_neg(ny);  n2 = non_neg(-nx); end
            SEC_3: begin n1 = non_neg(-nz); n2 = non_neg(nx);  end
            SEC_4: begin n1 = non_neg(-nx); n2 = non_neg(nz);  end
            SEC_5: begin n1 = non_neg(nx);  n2 = non_neg(-ny); end
            SEC_6: begin n1 = non_neg(-ny); n2 = non_neg(-nz); end
            default: ;
        endcase
        if (sec == SEC_ZERO || sec == 3'd7) return r;
        s = n1 + n2;
        if (s > d) begin
            r.ovm = (p != 0);
            tb = (p * n1) / (2 * s);
            tc = p >> 1;
        end else begin
            ta = (p * (d - s)) / (4 * d);
            tb = (p * (d + n1 - n2)) / (4 * d);
            tc = (p * (d + s)) / (4 * d);
        end
        // route times to channels by sector
        case (sec)
            SEC_1: begin
                r.ca = QUO_W'(tb); r.cb = QUO_W'(ta); r.cc = QUO_W'(tc);
            end
            SEC_2: begin
                r.ca = QUO_W'(ta); r.cb = QUO_W'(tc); r.cc = QUO_W'(tb);
            end
            SEC_3: begin
                r.ca = QUO_W'(ta); r.cb = QUO_W'(tb); r.cc = QUO_W'(tc);
            end
            SEC_4: begin
                r.ca = QUO_W'(tc); r.cb = QUO_W'(tb); r.cc = QUO_W'(ta);
            end
            SEC_5: begin
                r.ca = QUO_W'(tc); r.cb = QUO_W'(ta); r.cc = QUO_W'(tb);
            end
            default: begin
                r.ca = QUO_W'(tb); r.cb = QUO_W'(tc); r.cc = QUO_W'(ta);
            end
        endcase
        return r;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("MISMATCH %s: got %0d expected %0d (result %0d)", what, got, want,
                 o_result_count);
        o_fail_count++;
    endtask

    initial begin
        o_fail_count = 0;
        o_result_count = 0;
        o_ovm_count = 0;
    end

    assign o_pending = timing_q.size();

    // queue accepted vectors, check all three channels, sector and overmodulation on each accepted result
    always @(posedge i_clk) begin
        t_timing want;
        if (!i_rst_n) begin
            period_q <= PERIOD_RST;
            bus_q    <= BUS_RST;
            timing_q.delete();
        end else begin
            if (i_valid && i_ready_in) timing_q.push_back(svpwm_timing(i_alpha, i_beta));
            if (i_out_valid && i_out_ready) begin
                o_result_count++;
                if (timing_q.size() == 0) begin
                    report_mismatch("unexpected result", 1, 0);
                end else begin
                    want = timing_q.pop_front();
                    if (want.ovm) o_ovm_count++;
                    if (i_compare_a !== want.ca)
                        report_mismatch("compare_a", i_compare_a, want.ca);
                    if (i_compare_b !== want.cb)
                        report_mismatch("compare_b", i_compare_b, want.cb);
                    if (i_compare_c !== want.cc)
                        report_mismatch("compare_c", i_compare_c, want.cc);
                    if (i_sector_code !== want.sector)
                        report_mismatch("sector_code", i_sector_code, want.sector);
                    if (i_overmodulated !== want.ovm)
                        report_mismatch("overmodulated", i_overmodulated, want.ovm);
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == CFG_PERIOD) period_q <= i_cfg_data;
                else bus_q <= i_cfg_data;
            end
        end
    end

endmodule

>>> tb/sv/tb_space_vector_pwm_timing_top.sv
// Testbench top for the space vector PWM timing block: clock, reset, vector and
// config stimulus, output stall pattern, verdict. Uses svpt_pkg and svpt_checker.
module tb_space_vector_pwm_timing_top;
    import svpt_pkg::*;

    localparam int LATENCY   = 21;
    localparam int MAX_CYCLE = 400000;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_ready;
    logic signed [15:0] i_alpha;
    logic signed [15:0] i_beta;
    logic               i_cfg_valid;
    logic               o_cfg_ready;
    logic               i_cfg_index;
    logic [CFG_W-1:0]   i_cfg_data;
    logic               o_valid;
    logic               i_ready;
    logic [QUO_W-1:0]   o_compare_a;
    logic [QUO_W-1:0]   o_compare_b;
    logic [QUO_W-1:0]   o_compare_c;
    logic [2:0]         o_sector_code;
    logic               o_overmodulated;
    int                 fail_count;
    int                 pending;
    int                 result_count;
    int                 ovm_count;
    int                 cycle_count;
    int                 vector_count;
    int                 stall_mode;

    space_vector_pwm_timing_top dut (.*);

    svpt_checker checker_u (
        .i_clk, .i_rst_n, .i_valid, .i_ready_in(o_ready), .i_alpha, .i_beta,
        .i_cfg_valid, .i_cfg_ready(o_cfg_ready), .i_cfg_index, .i_cfg_data,
        .i_out_valid(o_valid), .i_out_ready(i_ready),
        .i_compare_a(o_compare_a), .i_compare_b(o_compare_b),
        .i_compare_c(o_compare_c), .i_sector_code(o_sector_code),
        .i_overmodulated(o_overmodulated),
        .o_fail_count(fail_count), .o_pending(pending),
        .o_result_count(result_count), .o_ovm_count(ovm_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // watchdog
    initial begin
        cycle_count = 0;
        forever begin
            @(posedge i_clk);
            cycle_count++;
            if (cycle_count > MAX_CYCLE) begin
                $display("timeout after %0d cycles", cycle_count);
                $display("space_vector_pwm_timing_top regression: fail");
                $finish;
            end
        end
    end

    // receiver stall pattern, mode changes per phase
    always @(posedge i_clk) begin
        case (stall_mode)
            0:       i_ready <= 1'b1;
            1:       i_ready <= ($urandom_range(0, 3) != 0);
            2:       i_ready <= ($urandom_range(0, 3) == 0);
            default: i_ready <= (cycle_count % 7) < 4;
        endcase
    end

    // one vector beat, burst gaps decided by caller
    task automatic send_vector(logic signed [15:0] alpha, logic signed [15:0] beta);
        i_valid <= 1'b1;
        i_alpha <= alpha;
        i_beta  <= beta;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        vector_count++;
    endtask

    task automatic idle_cycles(int n);
        i_valid <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    // one register beat, then the config channel is left idle before returning
    task automatic write_reg(t_cfg_idx idx, logic [CFG_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // wait for all results, then for pipeline drain
    task automatic drain();
        i_valid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    // random vectors in bursts; mostly moderate magnitude, some full range
    task automatic random_phase(int count);
        int left;
        int burst;
        logic signed [15:0] a;
        logic signed [15:0] b;
        left = count;
        while (left > 0) begin
            burst = $urandom_range(1, 12);
            while (burst > 0 && left > 0) begin
                case ($urandom_range(0, 3))
                    0: begin a = 16'($urandom); b = 16'($urandom); end
                    1: begin
                        a = $signed(16'($urandom_range(0, 4000))) - 16'sd2000;
                        b = $signed(16'($urandom_range(0, 4000))) - 16'sd2000;
                    end
                    2: begin
                        a = $signed(16'($urandom_range(0, 400))) - 16'sd200;
                        b = $signed(16'($urandom_range(0, 400))) - 16'sd200;
                    end
                    default: begin
                        // near a sector edge: beta about sqrt3*alpha
                        a = $signed(16'($urandom_range(0, 8000))) - 16'sd4000;
                        b = 16'((int'(a) * 1774) / 1024 + int'($urandom_range(0, 4)) - 2);
                        if ($urandom_range(0, 1)) b = -b;
                    end
                endcase
                send_vector(a, b);
                burst--;
                left--;
            end
            if ($urandom_range(0, 2) != 0) idle_cycles($urandom_range(1, 6));
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_alpha = '0;
        i_beta = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_PERIOD;
        i_cfg_data = '0;
        i_ready = 1'b1;
        stall_mode = 0;
        vector_count = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: zero vector, axes, extremes, every sector
        send_vector(16'sd0, 16'sd0);
        send_vector(16'sd256, 16'sd0);
        send_vector(-16'sd256, 16'sd0);
        send_vector(16'sd0, 16'sd256);
        send_vector(16'sd0, -16'sd256);
        send_vector(16'sd300, 16'sd100);
        send_vector(16'sd100, 16'sd300);
        send_vector(-16'sd100, 16'sd300);
        send_vector(-16'sd300, 16'sd100);
        send_vector(-16'sd300, -16'sd100);
        send_vector(-16'sd100, -16'sd300);
        send_vector(16'sd100, -16'sd300);
        send_vector(16'sd300, -16'sd100);
        send_vector(16'sd1000, 16'sd1732);
        send_vector(16'sd1000, -16'sd1733);
        send_vector(16'sh7fff, 16'sh7fff);
        send_vector(-16'sh8000, -16'sh8000);
        send_vector(16'sh7fff, -16'sh8000);
        send_vector(-16'sh8000, 16'sh7fff);
        send_vector(16'sd1, -16'sd1);
        send_vector(16'sh5555, 16'shaaaa);
        drain();

        // settings sweep: extremes, zero period, zero bus, reset values
        for (int ph = 0; ph < 7; ph++) begin
            stall_mode = ph % 4;
            case (ph)
                0: begin write_reg(CFG_PERIOD, 16'hffff); write_reg(CFG_BUS, 16'd1); end
                1: begin write_reg(CFG_PERIOD, 16'd1); write_reg(CFG_BUS, 16'hffff); end
                2: begin write_reg(CFG_PERIOD, 16'd0); write_reg(CFG_BUS, 16'd0); end
                3: begin write_reg(CFG_PERIOD, 16'd8000); write_reg(CFG_BUS, 16'd6144); end
                4: begin
                    write_reg(CFG_PERIOD, 16'($urandom));
                    write_reg(CFG_BUS, 16'($urandom));
                end
                5: begin write_reg(CFG_PERIOD, 16'hffff); write_reg(CFG_BUS, 16'hffff); end
                default: begin
                    write_reg(CFG_PERIOD, 16'($urandom_range(1000, 20000)));
                    write_reg(CFG_BUS, 16'($urandom_range(512, 8192)));
                end
            endcase
            if (ph == 2) send_vector(16'sd300, 16'sd100);
            random_phase(ph == 3 ? 200 : 75);
            drain();
        end

        $display("covered %0d vectors, %0d results, %0d overmodulated, 7 register settings",
                 vector_count, result_count, ovm_count);
        if (fail_count == 0) begin
            $display("space_vector_pwm_timing_top regression: pass");
        end else begin
            $display("space_vector_pwm_timing_top regression: fail");
        end
        $finish;
    end

endmodule

>>> filelist.f
design/svpt_pkg.sv
design/svpt_front.sv
design/svpt_div.sv
design/space_vector_pwm_timing_top.sv
tb/sv/svpt_checker.sv
tb/sv/tb_space_vector_pwm_timing_top.sv
